/* design/deq_pkg.sv */
// ============================================================================
// deq_pkg: shared types and constants for the deque with delete by value
// Operation codes, result status codes, the default queue depth and the word width.
// ============================================================================
package deq_pkg;

  // Default number of entries the queue holds
  localparam int DEPTH_DEFAULT = 16;

  // Word width of one queue entry
  localparam int WORD_W = 32;

  // Operation codes carried by a command transaction
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_COUNT      = 3'd5
  } op_t;

  // Status codes returned with each result transaction
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

/* design/deq_ram.sv */
// ============================================================================
// deq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered. No reset.
// ============================================================================
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/deq_slot_unit.sv */
// ============================================================================
// deq_slot_unit: circular slot address unit
// Adds an offset to the head index and wraps the sum into the store depth.
// Shared by every access the sequencer makes to the entry RAM.
// ============================================================================
module deq_slot_unit #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0] head,
  input  logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] slot
);

  localparam int AW = $clog2(DEPTH);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  // Add, then fold back once when the sum passes the end of the store
  always_comb begin
    sum     = {1'b0, head} + {1'b0, offset};
    wrapped = sum - (AW+1)'(DEPTH);
    if (sum >= (AW+1)'(DEPTH)) begin
      slot = wrapped[AW-1:0];
    end else begin
      slot = sum[AW-1:0];
    end
  end

endmodule

/* design/deq_seq.sv */
// ============================================================================
// deq_seq: command sequencer for the deque
// Holds head and count, steps through push, pop, scan and shift phases,
// and drives the entry RAM through the shared slot address unit.
// ============================================================================
module deq_seq #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [2:0]                   operation,
  input  logic signed [31:0]           value,
  output logic                         busy,
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [31:0]           item,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy,
  output logic [$clog2(DEPTH)-1:0]     head,
  output logic [$clog2(DEPTH)-1:0]     offset,
  input  logic [$clog2(DEPTH)-1:0]     slot,
  output logic                         mem_we,
  output logic [31:0]                  mem_wdata,
  input  logic [31:0]                  mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_RD_WAIT  = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CMP = 7'b0010000,
    S_SHIFT_RD = 7'b0100000,
    S_SHIFT_WR = 7'b1000000
  } state_t;

  state_t             state, state_next;
  deq_pkg::op_t       op_r, op_next;
  logic signed [31:0] val_r, val_next;
  logic [AW-1:0]      head_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic               done_next;
  deq_pkg::status_t   status_r, status_next;
  logic signed [31:0] item_r, item_next;

  logic               full;
  logic               empty;
  logic [CW-1:0]      count_dec;
  logic [CW:0]        idx_inc;
  logic [CW:0]        idx_inc2;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_dec = count - CW'(1);
  assign idx_inc   = {1'b0, idx} + (CW+1)'(1);
  assign idx_inc2  = {1'b0, idx} + (CW+1)'(2);

  // Sequence one command transaction
  always_comb begin
    state_next  = state;
    op_next     = op_r;
    val_next    = val_r;
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    done_next   = 1'b0;
    status_next = status_r;
    item_next   = item_r;
    offset      = '0;
    mem_we      = 1'b0;
    mem_wdata   = val_r;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = deq_pkg::op_t'(operation);
          val_next   = value;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (op_r)
          deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              done_next   = 1'b1;
              status_next = deq_pkg::ST_FULL;
              item_next   = '0;
              state_next  = S_IDLE;
            end else begin
              if (op_r == deq_pkg::OP_PUSH_BACK) begin
                offset = count[AW-1:0];
              end else begin
                offset    = AW'(DEPTH - 1);
                head_next = slot;
              end
              mem_we      = 1'b1;
              count_next  = count + CW'(1);
              done_next   = 1'b1;
              status_next = deq_pkg::ST_OK;
              item_next   = val_r;
              state_next  = S_IDLE;
            end
          end

          deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK, deq_pkg::OP_DELETE: begin
            if (empty) begin
              done_next   = 1'b1;
              status_next = deq_pkg::ST_EMPTY;
              item_next   = '0;
              state_next  = S_IDLE;
            end else if (op_r == deq_pkg::OP_DELETE) begin
              idx_next   = '0;
              state_next = S_SCAN_RD;
            end else begin
              // Present the front or back slot to the RAM read port
              if (op_r == deq_pkg::OP_POP_BACK) begin
                offset = count_dec[AW-1:0];
              end
              state_next = S_RD_WAIT;
            end
          end

          default: begin
            done_next   = 1'b1;
            status_next = deq_pkg::ST_OK;
            item_next   = '0;
            state_next  = S_IDLE;
          end
        endcase
      end

      // Take the popped word, advance head on a front pop
      S_RD_WAIT: begin
        offset = AW'(1);
        if (op_r == deq_pkg::OP_POP_FRONT) begin
          head_next = slot;
        end
        count_next  = count_dec;
        done_next   = 1'b1;
        status_next = deq_pkg::ST_OK;
        item_next   = mem_rdata;
        state_next  = S_IDLE;
      end

      S_SCAN_RD: begin
        offset     = idx[AW-1:0];
        state_next = S_SCAN_CMP;
      end

      // Compare the fetched entry against the search value
      S_SCAN_CMP: begin
        if (mem_rdata == val_r) begin
          if (idx_inc < {1'b0, count}) begin
            state_next = S_SHIFT_RD;
          end else begin
            count_next  = count_dec;
            done_next   = 1'b1;
            status_next = deq_pkg::ST_OK;
            item_next   = val_r;
            state_next  = S_IDLE;
          end
        end else if (idx_inc < {1'b0, count}) begin
          idx_next   = idx_inc[CW-1:0];
          state_next = S_SCAN_RD;
        end else begin
          done_next   = 1'b1;
          status_next = deq_pkg::ST_NOTFOUND;
          item_next   = '0;
          state_next  = S_IDLE;
        end
      end

      S_SHIFT_RD: begin
        offset     = idx_inc[AW-1:0];
        state_next = S_SHIFT_WR;
      end

      // Move the entry behind the gap up by one place
      S_SHIFT_WR: begin
        offset    = idx[AW-1:0];
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (idx_inc2 < {1'b0, count}) begin
          idx_next   = idx_inc[CW-1:0];
          state_next = S_SHIFT_RD;
        end else begin
          count_next  = count_dec;
          done_next   = 1'b1;
          status_next = deq_pkg::ST_OK;
          item_next   = val_r;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_next;
    val_r    <= val_next;
    idx      <= idx_next;
    status_r <= status_next;
    item_r   <= item_next;
  end

  assign busy      = (state != S_IDLE);
  assign status    = status_r;
  assign item      = item_r;
  assign occupancy = count;

endmodule

/* design/deque_with_value_delete_unit.sv */
// ============================================================================
// deque_with_value_delete_unit: bounded deque of 32-bit words
// Push and pop at both ends, delete first match by value, report count.
// ============================================================================
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for a single cycle with done high, and the
// receiver cannot hold it off. Push and count give their result from the
// execute state, pops from the read-wait state that follows it (from the
// execute state when the queue is empty). Delete by value reads one entry
// at a time through the single read port of the entry RAM, first in a read
// state and a compare state to find the match and then in a read state and
// a write state to move each later entry up one place. busy drops in the
// cycle the result is shown, so the next command may be taken then. The
// word of an entry never written is never used in a result.
module deque_with_value_delete_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 operation,
  input  logic signed [31:0]         value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic signed [31:0]         item,
  output logic [$clog2(DEPTH+1)-1:0] occupancy
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] head;
  logic [AW-1:0] offset;
  logic [AW-1:0] slot;
  logic          mem_we;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  // Sequencer
  deq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .value     (value),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .item      (item),
    .occupancy (occupancy),
    .head      (head),
    .offset    (offset),
    .slot      (slot),
    .mem_we    (mem_we),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Shared circular address unit
  deq_slot_unit #(.DEPTH(DEPTH)) u_slot (
    .head   (head),
    .offset (offset),
    .slot   (slot)
  );

  // Entry store
  deq_ram #(.WIDTH(deq_pkg::WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (mem_wdata),
    .raddr (slot),
    .rdata (mem_rdata)
  );

endmodule

/* design/deq_checker.sv */
// ============================================================================
// deq_checker: port-level assertions for the deque
// Watches command and result transactions on the top-level ports.
// ============================================================================
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [2:0]                 operation,
  input logic signed [31:0]         value,
  input logic                       done,
  input logic [1:0]                 status,
  input logic signed [31:0]         item,
  input logic [$clog2(DEPTH+1)-1:0] occupancy
);

  localparam int CW = $clog2(DEPTH+1);

  // A taken command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy next cycle");

  // A result is shown only once the block has finished the command
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while block still busy");

  // Refused or failed commands return no word
  a_fail_item: assert property (@(posedge clk) disable iff (rst)
    (done && status != deq_pkg::ST_OK) |-> (item == '0))
    else $error("nonzero item on a failed command");

  // A refused push only happens on a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == deq_pkg::ST_FULL) |-> (occupancy == CW'(DEPTH)))
    else $error("full status with queue not full");

  // Occupancy never passes the depth while a result is shown
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CW'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

bind deque_with_value_delete_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

/* tb/deque_with_value_delete_unit_tb.sv */
// ============================================================================
// deque_with_value_delete_unit_tb: self-checking bench for the deque unit
// Drives push, pop, delete-by-value and count commands in random bursts and
// compares each result against a mirror of the queue kept in the bench.
// ============================================================================
module deque_with_value_delete_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = deq_pkg::DEPTH_DEFAULT;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int RANDOM_COMMANDS = 600;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

  // Unused operation codes: the unit treats them as count
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_t;

  typedef struct {
    deq_pkg::status_t   status;
    logic signed [31:0] item;
    logic [OCC_W-1:0]   occupancy;
  } deque_result_t;

  // Mirror of the queue contents; predicts one result per command
  class deque_mirror;
    logic signed [31:0] words[DEPTH];
    int                 head;
    int                 count;
    int                 errors;
    deque_result_t      awaited[$];

    function new();
      head = 0;
      count = 0;
      errors = 0;
    endfunction

    function int slot(input int k);
      return (head + k) % DEPTH;
    endfunction

    function int held();
      return count;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic signed [31:0] held_word(input int k);
      return words[slot(k)];
    endfunction

    function bit holds(input logic signed [31:0] v);
      for (int k = 0; k < count; k++) begin
        if (words[slot(k)] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Apply one accepted command to the mirror and queue its result
    function void note_command(input logic [2:0] op, input logic signed [31:0] v);
      deque_result_t r;
      int            k;
      r.status = deq_pkg::ST_OK;
      r.item = '0;
      case (op)
        deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            r.status = deq_pkg::ST_FULL;
          end else begin
            if (op == deq_pkg::OP_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              words[head] = v;
            end else begin
              words[slot(count)] = v;
            end
            count++;
            r.item = v;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (count == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.item = words[head];
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (count == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.item = words[slot(count - 1)];
            count--;
          end
        end
        deq_pkg::OP_DELETE: begin
          if (count == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            k = 0;
            while (k < count && words[slot(k)] != v) k++;
            if (k == count) begin
              r.status = deq_pkg::ST_NOTFOUND;
            end else begin
              // Close the gap: later entries move up one place
              r.item = words[slot(k)];
              for (int j = k; j + 1 < count; j++) words[slot(j)] = words[slot(j + 1)];
              count--;
            end
          end
        end
        default: begin
        end
      endcase
      r.occupancy = OCC_W'(count);
      awaited.push_back(r);
    endfunction

    // Compare one result transaction against the oldest expectation
    function void check_result(input logic [1:0] st, input logic signed [31:0] it,
                               input logic [OCC_W-1:0] occ);
      deque_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status %0d item %0d occupancy %0d",
                 $time, st, it, occ);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d, got %0d", $time, e.status, st);
        errors++;
      end
      if (it !== e.item) begin
        $display("%0t: item expected %0d, got %0d", $time, e.item, it);
        errors++;
      end
      if (occ !== e.occupancy) begin
        $display("%0t: occupancy expected %0d, got %0d", $time, e.occupancy, occ);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [2:0]               operation = deq_pkg::OP_COUNT;
  logic signed [31:0]       value = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic signed [31:0]       item;
  logic [OCC_W-1:0]         occupancy;

  deque_mirror book = new();
  int          burst_left = 0;

  deque_with_value_delete_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .value(value),
    .done(done),
    .status(status),
    .item(item),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  // Check every result transaction on the cycle it is shown
  always @(posedge clk) begin
    if (!rst && done) book.check_result(status, item, occupancy);
  end

  // End the run if it hangs
  initial begin
    #(5_000_000);
    $display("deque_with_value_delete_unit_tb failed");
    $finish;
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7)) - 32'd4;
      1: begin
        case ($urandom_range(0, 3))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly aim deletes at a held word so matches are common
  function automatic logic signed [31:0] delete_target();
    if (book.held() > 0 && $urandom_range(0, 2) != 0)
      return book.held_word($urandom_range(0, book.held() - 1));
    return rand_word();
  endfunction

  function automatic logic [2:0] pick_op(input op_mix_t mix);
    int r;
    int push_w;
    int share;
    r = $urandom_range(0, 99);
    push_w = (mix == MIX_FILL) ? 36 : (mix == MIX_DRAIN) ? 10 : 22;
    share = (100 - 2 * push_w - 8) / 3;
    if (r < push_w) return deq_pkg::OP_PUSH_BACK;
    if (r < 2 * push_w) return deq_pkg::OP_PUSH_FRONT;
    r = r - 2 * push_w;
    if (r < share) return deq_pkg::OP_POP_FRONT;
    if (r < 2 * share) return deq_pkg::OP_POP_BACK;
    if (r < 3 * share) return deq_pkg::OP_DELETE;
    if (r < 3 * share + 5) return deq_pkg::OP_COUNT;
    return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 4);
      6, 7, 8: return $urandom_range(5, 15);
      default: return $urandom_range(16, 40);
    endcase
  endfunction

  // Hold one command until the unit takes it, then idle between bursts
  task automatic send_command(input logic [2:0] op, input logic signed [31:0] v);
    int gap;
    start <= 1'b1;
    operation <= op;
    value <= v;
    do @(posedge clk); while (busy);
    book.note_command(op, v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = pick_gap();
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] miss;
    logic [2:0]         op;
    op_mix_t            mix;
    int                 sent;
    int                 run_len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every removal and count on an empty queue, spare codes included
    send_command(deq_pkg::OP_COUNT, WORD_MAX);
    send_command(deq_pkg::OP_POP_FRONT, '0);
    send_command(deq_pkg::OP_POP_BACK, '0);
    send_command(deq_pkg::OP_DELETE, '0);
    send_command(OP_SPARE_A, WORD_MIN);
    send_command(OP_SPARE_B, -32'sd1);

    // Fill to capacity from both ends, extremes first
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: miss = WORD_MAX;
        1: miss = WORD_MIN;
        2: miss = '0;
        3: miss = -32'sd1;
        default: miss = rand_word();
      endcase
      send_command((i % 2 == 0) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT, miss);
    end
    send_command(deq_pkg::OP_PUSH_BACK, 32'sd5);
    send_command(deq_pkg::OP_PUSH_FRONT, 32'sd6);

    // Delete at the front, in the middle, at the back, and a miss
    send_command(deq_pkg::OP_DELETE, book.held_word(0));
    send_command(deq_pkg::OP_DELETE, book.held_word(DEPTH / 2));
    miss = 32'sh1357_2468;
    while (book.holds(miss)) miss = miss + 32'sd1;
    send_command(deq_pkg::OP_DELETE, miss);
    send_command(deq_pkg::OP_DELETE, book.held_word(book.held() - 1));
    wait_drained();

    // Random runs, each leaning toward filling, draining or neither
    sent = 0;
    while (sent < RANDOM_COMMANDS) begin
      mix = op_mix_t'($urandom_range(0, 2));
      run_len = $urandom_range(20, 60);
      for (int n = 0; n < run_len && sent < RANDOM_COMMANDS; n++) begin
        op = pick_op(mix);
        send_command(op, (op == deq_pkg::OP_DELETE) ? delete_target() : rand_word());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("deque_with_value_delete_unit_tb passed");
    end else begin
      $display("deque_with_value_delete_unit_tb failed");
    end
    $finish;
  end

endmodule

/* deque_with_value_delete_unit.f */
design/deq_pkg.sv
design/deq_ram.sv
design/deq_slot_unit.sv
design/deq_seq.sv
design/deque_with_value_delete_unit.sv
design/deq_checker.sv
tb/deque_with_value_delete_unit_tb.sv
